@@ design/assert_macros.svh @@
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is high.
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication whose consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ design/mbt_pkg.sv @@
package mbt_pkg;

   localparam int DEF_MAX_INPUTS     = 256;
   localparam int DEF_MAX_HIDDEN     = 64;
   localparam int DEF_MAX_OUTPUTS    = 16;
   localparam int DEF_SIGMOID_ENTRIES = 1024;

   // item kinds
   localparam logic [2:0] KIND_LOAD_IN_W  = 3'd0;
   localparam logic [2:0] KIND_LOAD_OUT_W = 3'd1;
   localparam logic [2:0] KIND_INPUT      = 3'd2;
   localparam logic [2:0] KIND_TARGET     = 3'd3;
   localparam logic [2:0] KIND_INFER      = 3'd4;
   localparam logic [2:0] KIND_TRAIN      = 3'd5;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUTS_USED   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIDDEN_USED   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUTS_USED  = 2'd3;

   localparam int CSR_DATA_W = 20;
   localparam int LR_W       = 20;
   localparam int INPUTS_W   = 9;
   localparam int HIDDEN_W   = 7;
   localparam int OUTPUTS_W  = 5;

   localparam int DEF_LR      = 124518;
   localparam int DEF_INPUTS  = 200;
   localparam int DEF_HIDDEN  = 16;
   localparam int DEF_OUTPUTS = 4;

   localparam int ACT_W    = 17;
   localparam int ACC_W    = 48;
   localparam int ONE_Q16  = 65536;
   localparam int SIG_HALF = 524288;

   typedef struct packed {
      logic [2:0]         kind;
      logic [13:0]        index;
      logic signed [31:0] value;
   } mbt_req_type;

   typedef struct packed {
      logic [3:0]  out_index;
      logic [16:0] out_value;
      logic [30:0] squared_error;
      logic        last;
   } mbt_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // elaboration-time helpers for the sigmoid table
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
      logic [64:0]     rem;
      longint unsigned quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic longint unsigned mul31(input longint unsigned a,
                                             input longint unsigned b);
      return (a * b + 64'd1073741824) >> 31;
   endfunction

   function automatic logic [ACT_W-1:0] sig_entry(input int n, input int e);
      longint unsigned q31, nn, t1, t2, t3, t4, r, res, base, d, v;
      longint          num;
      logic [19:0]     k;
      q31 = 64'd2147483648;
      nn = 64'(n);
      t1 = udiv64(q31, nn);
      t2 = udiv64(t1, 2 * nn);
      t3 = udiv64(t2, 3 * nn);
      t4 = udiv64(t3, 4 * nn);
      r = q31 - t1 + t2 - t3 + t4;
      num = 16 * longint'(e) - 8 * longint'(n);
      k = 20'(num < 0 ? -num : num);
      res = q31;
      base = r;
      for (int b = 0; b < 20; b++) begin
         if (k[b]) res = mul31(res, base);
         base = mul31(base, base);
      end
      d = q31 + res;
      if (num >= 0) v = udiv64((64'd1 << 47) + (d >> 1), d);
      else v = udiv64((res << 16) + (d >> 1), d);
      return ACT_W'(v);
   endfunction

endpackage

@@ design/mbt_ram.sv @@
module mbt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/mlp_backprop_trainer.sv @@
// Load items (weights, inputs, targets) are accepted only while idle; busy never rises for them.
// Infer and train runs share one 32x32 multiplier and one read per memory port a cycle.
// Train adds output and hidden delta passes and both weight updates after the forward pass.
// Results come at the end of a run, one per output neuron, each through the EM_RD then EM_SEND
// states; the receiver cannot stall.
// Synchronous reset restores the registers to defaults; weight and vector stores are
// not cleared and read as garbage until loaded.
module mlp_backprop_trainer import mbt_pkg::*; #(
   parameter int MAX_INPUTS      = DEF_MAX_INPUTS,
   parameter int MAX_HIDDEN      = DEF_MAX_HIDDEN,
   parameter int MAX_OUTPUTS     = DEF_MAX_OUTPUTS,
   parameter int SIGMOID_ENTRIES = DEF_SIGMOID_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  mbt_req_type           req_data,
   output logic                  rsp_strobe,
   output mbt_rsp_type           rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // memory geometry
   localparam int WIH_D  = MAX_INPUTS * MAX_HIDDEN;
   localparam int WHO_D  = MAX_HIDDEN * MAX_OUTPUTS;
   localparam int WIH_AW = (WIH_D > 1) ? $clog2(WIH_D) : 1;
   localparam int WHO_AW = (WHO_D > 1) ? $clog2(WHO_D) : 1;
   localparam int IW     = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int HW     = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
   localparam int OW     = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
   localparam int IUW    = $clog2(MAX_INPUTS + 1);
   localparam int HUW    = $clog2(MAX_HIDDEN + 1);
   localparam int OUW    = $clog2(MAX_OUTPUTS + 1);
   localparam int SW     = (SIGMOID_ENTRIES > 1) ? $clog2(SIGMOID_ENTRIES) : 1;

   localparam int RST_INPUTS  = (DEF_INPUTS > MAX_INPUTS) ? MAX_INPUTS : DEF_INPUTS;
   localparam int RST_HIDDEN  = (DEF_HIDDEN > MAX_HIDDEN) ? MAX_HIDDEN : DEF_HIDDEN;
   localparam int RST_OUTPUTS = (DEF_OUTPUTS > MAX_OUTPUTS) ? MAX_OUTPUTS : DEF_OUTPUTS;

   // sigmoid over [-8,8), built at elaboration, read through a register (ROM)
   typedef logic [ACT_W-1:0] sig_tab_type [SIGMOID_ENTRIES];

   function automatic sig_tab_type build_sig();
      sig_tab_type t;
      for (int e = 0; e < SIGMOID_ENTRIES; e++) t[e] = sig_entry(SIGMOID_ENTRIES, e);
      return t;
   endfunction

   localparam sig_tab_type SIG_TAB = build_sig();

   typedef enum logic [5:0] {
      IDLE,
      FH_RD, FH_MUL, FH_ACC, FH_SIG, FH_WR,
      FO_RD, FO_MUL, FO_ACC, FO_SIG, FO_WR,
      OD_RD, OD_DIF, OD_M1, OD_M2, OD_M3, OD_ERR,
      HD_RD, HD_MUL, HD_ACC, HD_H1, HD_H2, HD_WR,
      UO_E0, UO_E1, UO_E2, UO_RD, UO_MUL, UO_WR,
      UI_E0, UI_E1, UI_E2, UI_RD, UI_MUL, UI_WR,
      EM_RD, EM_SEND
   } state_type;

   state_type state_ff;

   // configuration
   logic [LR_W-1:0] lr_ff;
   logic [IUW-1:0]  in_used_ff;
   logic [HUW-1:0]  hid_used_ff;
   logic [OUW-1:0]  out_used_ff;

   // loop counters: ci input, cj hidden, ck output
   logic [IW-1:0] ci_ff;
   logic [HW-1:0] cj_ff;
   logic [OW-1:0] ck_ff;

   logic                    train_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] err_ff;
   logic signed [63:0]      prod_ff;
   logic signed [31:0]      tmp_ff;
   logic [ACT_W-1:0]        sig_ff;
   logic                    rsp_strobe_ff;
   mbt_rsp_type             rsp_data_ff;

   logic accept;
   assign accept = start && (state_ff == IDLE);
   assign busy = (state_ff != IDLE);

   // end-of-loop flags
   logic last_i, last_j, last_k;
   assign last_i = (IUW'(ci_ff) + IUW'(1)) == in_used_ff;
   assign last_j = (HUW'(cj_ff) + HUW'(1)) == hid_used_ff;
   assign last_k = (OUW'(ck_ff) + OUW'(1)) == out_used_ff;

   // memory read data
   logic signed [31:0] wih_rd, who_rd, x_rd, t_rd, od_rd, hd_rd;
   logic [ACT_W-1:0]   hact_raw, oact_raw;
   logic signed [31:0] hact_rd, oact_rd;
   assign hact_rd = 32'(hact_raw);
   assign oact_rd = 32'(oact_raw);

   // read/write addresses follow the counters
   logic [WIH_AW-1:0] wih_addr;
   logic [WHO_AW-1:0] who_addr;
   assign wih_addr = WIH_AW'(ci_ff * MAX_HIDDEN + cj_ff);
   assign who_addr = WHO_AW'(cj_ff * MAX_OUTPUTS + ck_ff);

   // shared Q16.16 multiplier; q is the floored, saturated product of last cycle
   logic signed [31:0] mul_a, mul_b, q;
   logic signed [63:0] prod_in;
   assign q = sat32(prod_ff >>> 16);
   assign prod_in = mul_a * mul_b;

   logic signed [31:0] eta, acc_sat;
   assign eta = 32'(lr_ff);
   assign acc_sat = sat32(64'(acc_ff));

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         FH_MUL: begin mul_a = x_rd; mul_b = wih_rd; end
         FO_MUL: begin mul_a = hact_rd; mul_b = who_rd; end
         OD_M1: begin mul_a = tmp_ff; mul_b = oact_rd; end
         OD_M2: begin mul_a = q; mul_b = 32'sd65536 - oact_rd; end
         OD_M3: begin mul_a = tmp_ff; mul_b = tmp_ff; end
         HD_MUL: begin mul_a = od_rd; mul_b = who_rd; end
         HD_H1: begin mul_a = hact_rd; mul_b = 32'sd65536 - hact_rd; end
         HD_H2: begin mul_a = q; mul_b = acc_sat; end
         UO_E1: begin mul_a = eta; mul_b = od_rd; end
         UI_E1: begin mul_a = eta; mul_b = hd_rd; end
         UO_MUL: begin mul_a = tmp_ff; mul_b = hact_rd; end
         UI_MUL: begin mul_a = tmp_ff; mul_b = x_rd; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // sigmoid index: saturate at both ends, else floor((x+8)*N/16)
   logic [SW-1:0] sig_idx;
   logic [19:0]   sig_off;
   always_comb begin
      sig_off = 20'(acc_sat + 32'sd524288);
      if (acc_sat < -32'sd524288) sig_idx = '0;
      else if (acc_sat >= 32'sd524288) sig_idx = SW'(SIGMOID_ENTRIES - 1);
      else sig_idx = SW'((64'(sig_off) * 64'(SIGMOID_ENTRIES)) >> 20);
   end

   logic signed [31:0] wih_upd, who_upd;
   assign wih_upd = sat32(64'(wih_rd) + 64'(q));
   assign who_upd = sat32(64'(who_rd) + 64'(q));

   // write ports: loads while idle, sequencer otherwise
   logic idle;
   assign idle = (state_ff == IDLE);

   logic wih_we, who_we, x_we, t_we;
   assign wih_we = (accept && req_data.kind == KIND_LOAD_IN_W
                    && 32'(req_data.index) < WIH_D) || state_ff == UI_WR;
   assign who_we = (accept && req_data.kind == KIND_LOAD_OUT_W
                    && 32'(req_data.index) < WHO_D) || state_ff == UO_WR;
   assign x_we = accept && req_data.kind == KIND_INPUT && 32'(req_data.index) < MAX_INPUTS;
   assign t_we = accept && req_data.kind == KIND_TARGET && 32'(req_data.index) < MAX_OUTPUTS;

   mbt_ram #(.WIDTH(32), .DEPTH(WIH_D)) u_wih (
      .clock(clock), .we(wih_we),
      .waddr(idle ? WIH_AW'(req_data.index) : wih_addr),
      .wdata(idle ? req_data.value : wih_upd),
      .raddr(wih_addr), .rdata(wih_rd)
   );

   mbt_ram #(.WIDTH(32), .DEPTH(WHO_D)) u_who (
      .clock(clock), .we(who_we),
      .waddr(idle ? WHO_AW'(req_data.index) : who_addr),
      .wdata(idle ? req_data.value : who_upd),
      .raddr(who_addr), .rdata(who_rd)
   );

   mbt_ram #(.WIDTH(32), .DEPTH(MAX_INPUTS)) u_x (
      .clock(clock), .we(x_we), .waddr(IW'(req_data.index)), .wdata(req_data.value),
      .raddr(ci_ff), .rdata(x_rd)
   );

   mbt_ram #(.WIDTH(32), .DEPTH(MAX_OUTPUTS)) u_t (
      .clock(clock), .we(t_we), .waddr(OW'(req_data.index)), .wdata(req_data.value),
      .raddr(ck_ff), .rdata(t_rd)
   );

   mbt_ram #(.WIDTH(ACT_W), .DEPTH(MAX_HIDDEN)) u_hact (
      .clock(clock), .we(state_ff == FH_WR), .waddr(cj_ff), .wdata(sig_ff),
      .raddr(cj_ff), .rdata(hact_raw)
   );

   mbt_ram #(.WIDTH(ACT_W), .DEPTH(MAX_OUTPUTS)) u_oact (
      .clock(clock), .we(state_ff == FO_WR), .waddr(ck_ff), .wdata(sig_ff),
      .raddr(ck_ff), .rdata(oact_raw)
   );

   mbt_ram #(.WIDTH(32), .DEPTH(MAX_OUTPUTS)) u_od (
      .clock(clock), .we(state_ff == OD_M3), .waddr(ck_ff), .wdata(q),
      .raddr(ck_ff), .rdata(od_rd)
   );

   mbt_ram #(.WIDTH(32), .DEPTH(MAX_HIDDEN)) u_hd (
      .clock(clock), .we(state_ff == HD_WR), .waddr(cj_ff), .wdata(q),
      .raddr(cj_ff), .rdata(hd_rd)
   );

   // size register writes, clamped to [1, MAX]
   logic [INPUTS_W-1:0]  csr_in_v;
   logic [HIDDEN_W-1:0]  csr_hid_v;
   logic [OUTPUTS_W-1:0] csr_out_v;
   assign csr_in_v  = csr_data[INPUTS_W-1:0];
   assign csr_hid_v = csr_data[HIDDEN_W-1:0];
   assign csr_out_v = csr_data[OUTPUTS_W-1:0];

   logic [30:0] err_sat;
   assign err_sat = (err_ff > ACC_W'(32'h7fffffff)) ? 31'h7fffffff : 31'(err_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         rsp_strobe_ff <= 1'b0;
         lr_ff         <= LR_W'(DEF_LR);
         in_used_ff    <= IUW'(RST_INPUTS);
         hid_used_ff   <= HUW'(RST_HIDDEN);
         out_used_ff   <= OUW'(RST_OUTPUTS);
      end else begin
         rsp_strobe_ff <= 1'b0;
         prod_ff <= prod_in;

         if (csr_we) begin
            unique case (csr_index)
               CSR_LEARNING_RATE: lr_ff <= csr_data[LR_W-1:0];
               CSR_INPUTS_USED:
                  if (csr_in_v == '0) in_used_ff <= IUW'(1);
                  else if (32'(csr_in_v) > MAX_INPUTS) in_used_ff <= IUW'(MAX_INPUTS);
                  else in_used_ff <= IUW'(csr_in_v);
               CSR_HIDDEN_USED:
                  if (csr_hid_v == '0) hid_used_ff <= HUW'(1);
                  else if (32'(csr_hid_v) > MAX_HIDDEN) hid_used_ff <= HUW'(MAX_HIDDEN);
                  else hid_used_ff <= HUW'(csr_hid_v);
               CSR_OUTPUTS_USED:
                  if (csr_out_v == '0) out_used_ff <= OUW'(1);
                  else if (32'(csr_out_v) > MAX_OUTPUTS) out_used_ff <= OUW'(MAX_OUTPUTS);
                  else out_used_ff <= OUW'(csr_out_v);
               default: ;
            endcase
         end

         unique case (state_ff)
            IDLE: begin
               if (accept && (req_data.kind == KIND_INFER || req_data.kind == KIND_TRAIN)) begin
                  train_ff <= (req_data.kind == KIND_TRAIN);
                  ci_ff    <= '0;
                  cj_ff    <= '0;
                  ck_ff    <= '0;
                  acc_ff   <= '0;
                  err_ff   <= '0;
                  state_ff <= FH_RD;
               end
            end

            // hidden layer: acc over inputs, then sigmoid
            FH_RD:  state_ff <= FH_MUL;
            FH_MUL: state_ff <= FH_ACC;
            FH_ACC: begin
               acc_ff <= acc_ff + ACC_W'(q);
               if (last_i) state_ff <= FH_SIG;
               else begin
                  ci_ff    <= ci_ff + IW'(1);
                  state_ff <= FH_RD;
               end
            end
            FH_SIG: begin
               sig_ff   <= SIG_TAB[sig_idx];
               state_ff <= FH_WR;
            end
            FH_WR: begin
               acc_ff <= '0;
               ci_ff  <= '0;
               if (last_j) begin
                  cj_ff    <= '0;
                  ck_ff    <= '0;
                  state_ff <= FO_RD;
               end else begin
                  cj_ff    <= cj_ff + HW'(1);
                  state_ff <= FH_RD;
               end
            end

            // output layer
            FO_RD:  state_ff <= FO_MUL;
            FO_MUL: state_ff <= FO_ACC;
            FO_ACC: begin
               acc_ff <= acc_ff + ACC_W'(q);
               if (last_j) state_ff <= FO_SIG;
               else begin
                  cj_ff    <= cj_ff + HW'(1);
                  state_ff <= FO_RD;
               end
            end
            FO_SIG: begin
               sig_ff   <= SIG_TAB[sig_idx];
               state_ff <= FO_WR;
            end
            FO_WR: begin
               acc_ff <= '0;
               cj_ff  <= '0;
               if (last_k) begin
                  ck_ff    <= '0;
                  state_ff <= train_ff ? OD_RD : EM_RD;
               end else begin
                  ck_ff    <= ck_ff + OW'(1);
                  state_ff <= FO_RD;
               end
            end

            // output deltas and squared error
            OD_RD: state_ff <= OD_DIF;
            OD_DIF: begin
               tmp_ff   <= sat32(64'(t_rd) - 64'(oact_rd));
               state_ff <= OD_M1;
            end
            OD_M1: state_ff <= OD_M2;
            OD_M2: state_ff <= OD_M3;
            OD_M3: state_ff <= OD_ERR;
            OD_ERR: begin
               err_ff <= err_ff + ACC_W'(q);
               if (last_k) begin
                  ck_ff    <= '0;
                  cj_ff    <= '0;
                  state_ff <= HD_RD;
               end else begin
                  ck_ff    <= ck_ff + OW'(1);
                  state_ff <= OD_RD;
               end
            end

            // hidden deltas
            HD_RD:  state_ff <= HD_MUL;
            HD_MUL: state_ff <= HD_ACC;
            HD_ACC: begin
               acc_ff <= acc_ff + ACC_W'(q);
               if (last_k) state_ff <= HD_H1;
               else begin
                  ck_ff    <= ck_ff + OW'(1);
                  state_ff <= HD_RD;
               end
            end
            HD_H1: state_ff <= HD_H2;
            HD_H2: state_ff <= HD_WR;
            HD_WR: begin
               acc_ff <= '0;
               ck_ff  <= '0;
               if (last_j) begin
                  cj_ff    <= '0;
                  state_ff <= UO_E0;
               end else begin
                  cj_ff    <= cj_ff + HW'(1);
                  state_ff <= HD_RD;
               end
            end

            // output weight update, column by column
            UO_E0: state_ff <= UO_E1;
            UO_E1: state_ff <= UO_E2;
            UO_E2: begin
               tmp_ff   <= q;
               state_ff <= UO_MUL;
            end
            UO_RD:  state_ff <= UO_MUL;
            UO_MUL: state_ff <= UO_WR;
            UO_WR: begin
               if (last_j) begin
                  cj_ff <= '0;
                  if (last_k) begin
                     ck_ff    <= '0;
                     ci_ff    <= '0;
                     state_ff <= UI_E0;
                  end else begin
                     ck_ff    <= ck_ff + OW'(1);
                     state_ff <= UO_E0;
                  end
               end else begin
                  cj_ff    <= cj_ff + HW'(1);
                  state_ff <= UO_RD;
               end
            end

            // input weight update, one hidden neuron at a time
            UI_E0: state_ff <= UI_E1;
            UI_E1: state_ff <= UI_E2;
            UI_E2: begin
               tmp_ff   <= q;
               state_ff <= UI_MUL;
            end
            UI_RD:  state_ff <= UI_MUL;
            UI_MUL: state_ff <= UI_WR;
            UI_WR: begin
               if (last_i) begin
                  ci_ff <= '0;
                  if (last_j) begin
                     cj_ff    <= '0;
                     ck_ff    <= '0;
                     state_ff <= EM_RD;
                  end else begin
                     cj_ff    <= cj_ff + HW'(1);
                     state_ff <= UI_E0;
                  end
               end else begin
                  ci_ff    <= ci_ff + IW'(1);
                  state_ff <= UI_RD;
               end
            end

            // one result item per output neuron
            EM_RD: state_ff <= EM_SEND;
            EM_SEND: begin
               rsp_strobe_ff               <= 1'b1;
               rsp_data_ff.out_index       <= 4'(ck_ff);
               rsp_data_ff.out_value       <= oact_raw;
               rsp_data_ff.squared_error   <= last_k ? err_sat : '0;
               rsp_data_ff.last            <= last_k;
               if (last_k) state_ff <= IDLE;
               else begin
                  ck_ff    <= ck_ff + OW'(1);
                  state_ff <= EM_RD;
               end
            end

            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

@@ design/mbt_chk.sv @@
`include "assert_macros.svh"

module mbt_chk import mbt_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input mbt_req_type req_data,
   input logic        rsp_strobe,
   input mbt_rsp_type rsp_data
);

   logic run_item;
   assign run_item = start && !busy
                     && (req_data.kind == KIND_INFER || req_data.kind == KIND_TRAIN);

   `ASSERT_NEXT(a_run_goes_busy, clock, reset, run_item, busy, "run item did not start")
   `ASSERT_NEXT(a_load_stays_idle, clock, reset, start && !busy && !run_item, !busy,
                "load item raised busy")
   `ASSERT_NEXT(a_last_ends_burst, clock, reset, rsp_strobe && rsp_data.last, !rsp_strobe,
                "result after last")
   `ASSERT_AT(a_mid_result, clock, reset,
              rsp_strobe && !rsp_data.last |-> busy && rsp_data.squared_error == 0,
              "non-last result outside run or with error")

endmodule

bind mlp_backprop_trainer mbt_chk u_mbt_chk (.*);
